// ----- rtl/cbspe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbspe_pkg
// Shared types and constants of the cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
package cbspe_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int BANKS        = 4;
    localparam int BANK_DEPTH   = MAX_POINTS / BANKS;
    localparam int COORD_W      = 32;
    localparam int POINT_W      = 3 * COORD_W;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int PARAM_W      = 17;
    localparam int FRAC_W       = 16;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_EVAL   = 1'b1;

    // exact x/3 for 32-bit x: (x * RECIP3) >> 33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

endpackage

// ----- rtl/cbspe_ram.sv -----
// ----------------------------------------------------------------------------
// cbspe_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module cbspe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read-before-write on a same-address collision
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/cubic_bspline_point_evaluator.sv -----
// ----------------------------------------------------------------------------
// cubic_bspline_point_evaluator
// Uniform cubic B-spline evaluation over a table of 3-D Q16.16 control points.
// ----------------------------------------------------------------------------
// Use:
//   Input stream s_*: tuser[0] is the action. A write request (action 0)
//   stores point_x/y/z at point_index and gives no result. An evaluate request
//   (action 1) takes curve_param u in Q1.16 and returns one result on m_*:
//   the blended point and the first control point index used.
//   cfg_wr_en/cfg_wr_data set points_in_use (n, clamped to 4..64); write it
//   only while the block is idle.
// Throughput: one request per cycle while m_* is not stalled; the table is
//   split over four RAM banks by index mod 4 so the four consecutive points
//   of a segment are read together, one read port per bank. A write request
//   passes four delay registers and reaches the table at the same point as
//   the table read of an evaluate request, so request order is kept.
// Reset: aresetn clears the pipeline valids and sets n to 4; the point table
//   is not cleared and must be written before use.
// Stall: the whole pipeline, including the RAM read register, holds while
//   m_tvalid is high and m_tready low; s_tready drops in that case, so no
//   request is lost or repeated.
// ----------------------------------------------------------------------------
module cubic_bspline_point_evaluator (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,   // points_in_use
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_index[5:0], point_x[37:6], point_y[69:38], point_z[101:70],
    // curve_param[118:102], zero pad [119]
    input  logic [119:0] s_tdata,
    input  logic [0:0]   s_tuser,       // action[0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // curve_x[31:0], curve_y[63:32], curve_z[95:64], segment_used[101:96],
    // zero pad [103:102]
    output logic [103:0] m_tdata
);

    localparam int NSTG = 8;

    // ---------------- control --------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            en;
    logic            s_acc;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- configuration --------------------------------------
    logic [cbspe_pkg::CNT_W-1:0] n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= 7'd4;
        end else if (cfg_wr_en) begin
            n_reg <= cfg_wr_data;
        end
    end

    // ---------------- input unpack ---------------------------------------
    logic                          in_act;
    logic [cbspe_pkg::IDX_W-1:0]   in_idx;
    cbspe_pkg::point_t             in_pt;
    logic [cbspe_pkg::PARAM_W-1:0] in_u;

    assign in_act   = s_tuser[0];
    assign in_idx   = s_tdata[5:0];
    assign in_pt    = s_tdata[101:6];   // x lowest, then y, z
    assign in_u     = s_tdata[118:102];

    // ---------------- write delay line -----------------------------------
    // point writes travel four stages so they hit the table in request order
    // relative to the table reads of evaluate requests
    logic                        wv_reg   [4];
    logic [cbspe_pkg::IDX_W-1:0] widx_reg [4];
    cbspe_pkg::point_t           wpt_reg  [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                wv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            wv_reg[0] <= s_acc && (in_act == cbspe_pkg::ACT_WRITE);
            for (int k = 1; k < 4; k++) begin
                wv_reg[k] <= wv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            widx_reg[0] <= in_idx;
            wpt_reg[0]  <= in_pt;
            for (int k = 1; k < 4; k++) begin
                widx_reg[k] <= widx_reg[k-1];
                wpt_reg[k]  <= wpt_reg[k-1];
            end
        end
    end

    // ---------------- stage 1: segment and local fraction ----------------
    logic [6:0]  n_sat;
    logic [6:0]  n_m3;
    logic [22:0] prod;
    logic [5:0]  s1_next;
    logic [16:0] t1_next;
    logic [5:0]  s1_reg;
    logic [16:0] t1_reg;

    always_comb begin
        if (n_reg < 7'd4) begin
            n_sat = 7'd4;
        end else if (n_reg > 7'(cbspe_pkg::MAX_POINTS)) begin
            n_sat = 7'(cbspe_pkg::MAX_POINTS);
        end else begin
            n_sat = n_reg;
        end
        n_m3 = n_sat - 7'd3;
        prod = 23'(in_u[15:0]) * 23'(n_m3);
        if (in_u[16]) begin
            // u at or above 1.0: last segment, t = 1.0
            s1_next = 6'(n_sat - 7'd4);
            t1_next = 17'h1_0000;
        end else begin
            s1_next = prod[21:16];
            t1_next = {1'b0, prod[15:0]};
        end
    end

    // ---------------- stage 2/3: powers of t -----------------------------
    logic [5:0]  s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    logic [16:0] t2_reg, t3_reg;
    logic [33:0] tt2_reg, tt3_reg;
    logic [50:0] ttt3_reg;

    // ---------------- stage 4: basis numerators, /2^19 with rounding -----
    logic signed [53:0] num [4];
    logic signed [53:0] a_t, a_tt, a_ttt, one3;
    logic [31:0]        q4_reg [4];

    always_comb begin
        one3  = 54'sd1 <<< 48;
        a_t   = $signed(54'(t3_reg)) <<< 32;
        a_tt  = $signed(54'(tt3_reg)) <<< 16;
        a_ttt = $signed(54'(ttt3_reg));
        num[0] = one3 - 54'sd3 * a_t + 54'sd3 * a_tt - a_ttt;
        num[1] = 54'sd3 * a_ttt - 54'sd6 * a_tt + 54'sd4 * one3;
        num[2] = -54'sd3 * a_ttt + 54'sd3 * a_tt + 54'sd3 * a_t + one3;
        num[3] = a_ttt;
    end

    // ---------------- stage 5: weights = q / 3 ---------------------------
    logic [30:0] w5_reg [4];
    logic [63:0] wq [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            wq[k] = 64'(q4_reg[k]) * 64'(cbspe_pkg::RECIP3);
        end
    end

    // ---------------- point table: four banks ----------------------------
    localparam int BA_W = $clog2(cbspe_pkg::BANK_DEPTH);

    cbspe_pkg::point_t rd_pt [cbspe_pkg::BANKS];

    for (genvar b = 0; b < cbspe_pkg::BANKS; b++) begin : g_bank
        logic [1:0]  off;
        logic [5:0]  ridx;
        logic        bwr;

        assign off  = 2'(b) - s4_reg[1:0];
        assign ridx = s4_reg + 6'(off);
        assign bwr  = en && wv_reg[3] && (widx_reg[3][1:0] == 2'(b));

        cbspe_ram #(
            .WIDTH (cbspe_pkg::POINT_W),
            .DEPTH (cbspe_pkg::BANK_DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (bwr),
            .wr_addr (widx_reg[3][5:2]),
            .wr_data (wpt_reg[3]),
            .rd_en   (en),
            .rd_addr (ridx[BA_W+1:2]),
            .rd_data (rd_pt[b])
        );
    end

    // ---------------- stage 6: weight * point ----------------------------
    cbspe_pkg::point_t  seg_pt [4];
    logic signed [63:0] px6_reg [4];
    logic signed [63:0] py6_reg [4];
    logic signed [63:0] pz6_reg [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            seg_pt[k] = rd_pt[2'(s5_reg[1:0] + 2'(k))];
        end
    end

    // ---------------- stage 7: sums --------------------------------------
    logic signed [65:0] ax7_reg, ay7_reg, az7_reg;

    // ---------------- stage 8: round, saturate ---------------------------
    function automatic logic [31:0] round_sat(input logic signed [65:0] acc);
        logic signed [65:0] r;
        logic signed [35:0] q;
        r = acc + (66'sd1 <<< 29);
        q = 36'(r >>> 30);
        if (q > 36'sh7FFF_FFFF) begin
            round_sat = 32'h7FFF_FFFF;
        end else if (q < -36'sh8000_0000) begin
            round_sat = 32'h8000_0000;
        end else begin
            round_sat = q[31:0];
        end
    endfunction

    logic [31:0] ox_reg, oy_reg, oz_reg;

    // ---------------- pipeline registers ---------------------------------
    always_comb begin
        vld_next = {vld_reg[NSTG-2:0], s_acc && (in_act == cbspe_pkg::ACT_EVAL)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            t1_reg   <= t1_next;
            s2_reg   <= s1_reg;
            t2_reg   <= t1_reg;
            tt2_reg  <= 34'(t1_reg) * 34'(t1_reg);
            s3_reg   <= s2_reg;
            t3_reg   <= t2_reg;
            tt3_reg  <= tt2_reg;
            ttt3_reg <= 51'(tt2_reg) * 51'(t2_reg);
            s4_reg   <= s3_reg;
            for (int k = 0; k < 4; k++) begin
                q4_reg[k] <= 32'((num[k] + (54'sd3 <<< 18)) >>> 19);
                w5_reg[k] <= wq[k][63:33];
                px6_reg[k] <= $signed({1'b0, w5_reg[k]}) * seg_pt[k].x;
                py6_reg[k] <= $signed({1'b0, w5_reg[k]}) * seg_pt[k].y;
                pz6_reg[k] <= $signed({1'b0, w5_reg[k]}) * seg_pt[k].z;
            end
            s5_reg  <= s4_reg;
            s6_reg  <= s5_reg;
            ax7_reg <= 66'(px6_reg[0]) + 66'(px6_reg[1]) + 66'(px6_reg[2])
                       + 66'(px6_reg[3]);
            ay7_reg <= 66'(py6_reg[0]) + 66'(py6_reg[1]) + 66'(py6_reg[2])
                       + 66'(py6_reg[3]);
            az7_reg <= 66'(pz6_reg[0]) + 66'(pz6_reg[1]) + 66'(pz6_reg[2])
                       + 66'(pz6_reg[3]);
            s7_reg  <= s6_reg;
            ox_reg  <= round_sat(ax7_reg);
            oy_reg  <= round_sat(ay7_reg);
            oz_reg  <= round_sat(az7_reg);
            s8_reg  <= s7_reg;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {2'b00, s8_reg, oz_reg, oy_reg, ox_reg};

    // ---------------- assertions -----------------------------------------
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_eval_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_act == cbspe_pkg::ACT_EVAL) |=> vld_reg[0])
        else $error("evaluate request not entered into pipeline");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_act == cbspe_pkg::ACT_WRITE) |=> !vld_reg[0])
        else $error("write request produced a pipeline entry");

    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[101:96] <= 6'd60))
        else $error("segment index out of range");

endmodule

// ----- dv/cubic_bspline_point_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// cubic_bspline_point_evaluator_tb
// Self-checking bench for the cubic B-spline point evaluator: a table of
// directed requests, then random writes and evaluations under several point
// counts, with random idling on both streams and a scoreboard fed by a
// bit-exact blending predictor.
// ----------------------------------------------------------------------------
module cubic_bspline_point_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbspe_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_WAIT   = 12;     // pipeline is 8 deep, plus margin
    localparam int  PHASE_ITEMS  = 120;

    typedef struct packed {
        logic               act;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        px;
        logic [31:0]        py;
        logic [31:0]        pz;
        logic [PARAM_W-1:0] u;
    } request_t;

    typedef struct packed {
        logic [31:0]      cx;
        logic [31:0]      cy;
        logic [31:0]      cz;
        logic [IDX_W-1:0] seg;
    } curve_pt_t;

    // one row of the directed table; typed expectation where obvious
    typedef struct packed {
        request_t  req;
        logic      typed;
        curve_pt_t want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    // predictor state
    logic signed [31:0] pt_x [MAX_POINTS];
    logic signed [31:0] pt_y [MAX_POINTS];
    logic signed [31:0] pt_z [MAX_POINTS];
    logic [6:0]         n_points = 7'd4;

    curve_pt_t pending_pts[$];
    int        fails = 0;
    int        cycles = 0;
    int        n_evals = 0;
    int        n_writes = 0;
    int        n_checked = 0;
    bit        quiet = 1'b0;     // no idling on either side while set

    always #4 aclk = ~aclk;

    cubic_bspline_point_evaluator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // weight of one basis term, rounded half up into Q0.30
    function automatic longint to_q30(longint num);
        longint d;
        d = longint'(6) << 18;
        return (num + d / 2) / d;
    endfunction

    function automatic logic [31:0] mix_coord(logic signed [31:0] a, logic signed [31:0] b,
                                              logic signed [31:0] c, logic signed [31:0] d,
                                              longint w0, longint w1, longint w2, longint w3);
        longint acc;
        acc = w0 * longint'(a) + w1 * longint'(b) + w2 * longint'(c) + w3 * longint'(d);
        acc = (acc + (longint'(1) << 29)) >>> 30;   // floor after half-up bias
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic curve_pt_t eval_curve(logic [PARAM_W-1:0] u);
        curve_pt_t r;
        int        n;
        int        s;
        longint    t;
        longint    big;
        longint    prod;
        longint    w0, w1, w2, w3;
        n = (n_points < 4) ? 4 : (n_points > MAX_POINTS) ? MAX_POINTS : n_points;
        big = longint'(1) << FRAC_W;
        if (u >= big) begin
            s = n - 4;
            t = big;
        end else begin
            prod = longint'(u) * (n - 3);
            s = int'(prod >> FRAC_W);
            t = prod & (big - 1);
        end
        w0 = to_q30((big - t) * (big - t) * (big - t));
        w1 = to_q30(3 * t * t * t - 6 * t * t * big + 4 * big * big * big);
        w2 = to_q30(-3 * t * t * t + 3 * t * t * big + 3 * t * big * big + big * big * big);
        w3 = to_q30(t * t * t);
        r.cx  = mix_coord(pt_x[s], pt_x[s+1], pt_x[s+2], pt_x[s+3], w0, w1, w2, w3);
        r.cy  = mix_coord(pt_y[s], pt_y[s+1], pt_y[s+2], pt_y[s+3], w0, w1, w2, w3);
        r.cz  = mix_coord(pt_z[s], pt_z[s+1], pt_z[s+2], pt_z[s+3], w0, w1, w2, w3);
        r.seg = s[IDX_W-1:0];
        return r;
    endfunction

    // drive one request from the falling edge and hold it until taken
    task automatic send_request(request_t rq, bit typed, curve_pt_t want);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.act;
        s_tdata  <= {1'b0, rq.u, rq.pz, rq.py, rq.px, rq.idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (rq.act == ACT_WRITE) begin
            pt_x[rq.idx] = rq.px;
            pt_y[rq.idx] = rq.py;
            pt_z[rq.idx] = rq.pz;
            n_writes++;
        end else begin
            pending_pts = {pending_pts, (typed ? want : eval_curve(rq.u))};
            n_evals++;
        end
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait out every outstanding result plus the pipeline depth
    task automatic drain();
        while (pending_pts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_points(logic [6:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        n_points = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t rq;
        rq.act = ($urandom_range(3) == 0) ? ACT_WRITE : ACT_EVAL;
        rq.idx = IDX_W'($urandom_range(MAX_POINTS - 1));
        rq.px  = rand_coord();
        rq.py  = rand_coord();
        rq.pz  = rand_coord();
        case ($urandom_range(9))
            0: rq.u = '0;
            1: rq.u = 17'h10000;
            2: rq.u = PARAM_W'($urandom_range(17'h1FFFF, 17'h10001));
            default: rq.u = PARAM_W'($urandom_range(17'hFFFF));
        endcase
        return rq;
    endfunction

    function automatic request_t wr_req(int idx, logic [31:0] v);
        return '{ACT_WRITE, idx[IDX_W-1:0], v, v, v, 17'h0};
    endfunction

    function automatic request_t ev_req(logic [PARAM_W-1:0] u);
        return '{ACT_EVAL, 6'd0, 32'h0, 32'h0, 32'h0, u};
    endfunction

    // result side: random back-pressure, changed on the falling edge
    always @(negedge aclk)
        m_tready <= quiet || ($urandom_range(99) >= 23);

    // scoreboard
    always @(posedge aclk) begin
        curve_pt_t want;
        curve_pt_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[101:96]};
            if (pending_pts.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                fails++;
            end else begin
                want = pending_pts.pop_front();
                n_checked++;
                if (got.cx !== want.cx) begin
                    $error("curve_x expected %h actual %h", want.cx, got.cx);
                    fails++;
                end
                if (got.cy !== want.cy) begin
                    $error("curve_y expected %h actual %h", want.cy, got.cy);
                    fails++;
                end
                if (got.cz !== want.cz) begin
                    $error("curve_z expected %h actual %h", want.cz, got.cz);
                    fails++;
                end
                if (got.seg !== want.seg) begin
                    $error("segment_used expected %0d actual %0d", want.seg, got.seg);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_pts.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        row_t       rows[$];
        curve_pt_t  none;
        logic [6:0] settings[$];
        none = '0;

        // points 0..3 zero, then full-scale positive, then full-scale negative;
        // weights sum to just over one so the extremes saturate
        for (int i = 0; i < 4; i++)
            rows = {rows, row_t'{wr_req(i, 32'h0), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h0), 1'b1, '{32'h0, 32'h0, 32'h0, 6'd0}}};
        rows = {rows, row_t'{ev_req(17'h10000), 1'b1, '{32'h0, 32'h0, 32'h0, 6'd0}}};
        for (int i = 0; i < 4; i++)
            rows = {rows, row_t'{wr_req(i, 32'h7FFF_FFFF), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h0), 1'b1,
                             '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0}}};
        for (int i = 0; i < 4; i++)
            rows = {rows, row_t'{wr_req(i, 32'h8000_0000), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h0), 1'b1,
                             '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd0}}};
        // mixed points, parameter above one, just below one, smallest step, one half
        rows = {rows, row_t'{'{ACT_WRITE, 6'd1, 32'h0001_8000, 32'hFFFE_0000,
                               32'h1234_5678, 17'h1FFFF}, 1'b0, none}};
        rows = {rows, row_t'{'{ACT_WRITE, 6'd63, 32'hFFFF_FFFF, 32'h0000_0001,
                               32'hAAAA_5555, 17'h0}, 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h1FFFF), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'hFFFF), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h1), 1'b0, none}};
        rows = {rows, row_t'{ev_req(17'h8000), 1'b0, none}};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every slot written before any evaluation can read it
        for (int i = 0; i < MAX_POINTS; i++)
            send_request('{ACT_WRITE, i[IDX_W-1:0], rand_coord(), rand_coord(),
                           rand_coord(), PARAM_W'($urandom)}, 1'b0, none);

        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].want);
        drop_valid();

        // point counts: both ends of the legal range, values inside it, clamped values beyond it, one random count
        settings = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd4, 7'd37, 7'd65, 7'd3};
        settings = {settings, 7'($urandom_range(127))};
        foreach (settings[p]) begin
            drain();
            set_points(settings[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                quiet = (p == 3) && (i >= 20) && (i < 100);
                send_request(rand_request(), 1'b0, none);
            end
            quiet = 1'b0;
            drop_valid();
        end

        drain();
        $display("Covered %0d point writes and %0d evaluations over %0d point counts,",
                 n_writes, n_evals, settings.size() + 1);
        $display("%0d results compared, %0d mismatches", n_checked, fails);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cbspe_pkg.sv
rtl/cbspe_ram.sv
rtl/cubic_bspline_point_evaluator.sv
dv/cubic_bspline_point_evaluator_tb.sv
